FILE: sv/pcg_pkg.sv
package pcg_pkg;

  localparam int MAX_DRAWS  = 64;
  localparam int DRAW_CNT_W = $clog2(MAX_DRAWS + 1);
  localparam int DIV_BITS   = 64;
  localparam int DIV_CNT_W  = $clog2(DIV_BITS);

  localparam logic [63:0] PCG_MUL     = 64'd6364136223846793005;
  localparam logic [63:0] PCG_INC     = 64'd1442695040888963407;
  localparam logic [63:0] RESET_STATE = 64'(PCG_INC * PCG_MUL + PCG_INC);

  localparam logic [1:0] ACT_U32   = 2'd0;
  localparam logic [1:0] ACT_U64   = 2'd1;
  localparam logic [1:0] ACT_RANGE = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [63:0] range_low;
    logic signed [63:0] range_high;
  } in_t;

  typedef struct packed {
    logic [63:0] value;
    logic        gave_up;
  } out_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_DRAW,
    RES_HI_LO,
    RES_LO,
    RES_LO_DRAW,
    RES_LO_REM
  } res_sel_e;

  typedef struct packed {
    logic     capture;
    logic     draw_start;
    logic     mul_go;
    logic     save_hi;
    logic     cnt_clr;
    logic     div_start;
    logic     div_thr;
    logic     thr_load;
    logic     res_load;
    res_sel_e res_sel;
    logic     gave_up;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       mul_done;
    logic       div_done;
    logic       inverted;
    logic       span_zero;
    logic       draw_ok;
    logic       cnt_max;
    logic [1:0] action;
  } dp_status_t;

endpackage

FILE: sv/pcg_rem.sv
module pcg_rem import pcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]          dvd_q, dvd_d;
  logic [63:0]          rem_q, rem_d;
  logic [63:0]          dsr_q, dsr_d;
  logic [64:0]          shifted;

  assign shifted = {rem_q, dvd_q[63]};
  assign done_o  = done_q;
  assign rem_o   = rem_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[62:0], 1'b0};
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = 64'(shifted - {1'b0, dsr_q});
      end else begin
        rem_d = shifted[63:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

endmodule

FILE: sv/pcg_dp.sv
module pcg_dp import pcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  in_t         in_data_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  output out_t        out_data_o
);

  logic [63:0]           state_q;
  logic [63:0]           mul_x_q;
  logic [63:0]           prod_q;
  logic [63:0]           acc_q;
  logic [1:0]            step_q;
  logic                  busy_q;
  logic [31:0]           mul_a, mul_b;
  logic [31:0]           r_q, hi_q;
  logic [1:0]            act_q;
  logic [63:0]           lo_q, hi_bound_q, span_q, thr_q, res_q;
  logic                  gave_q;
  logic [DRAW_CNT_W-1:0] cnt_q;
  out_t                  out_q;
  logic [63:0]           mixed_w;
  logic [63:0]           rot_w;
  logic [31:0]           draw_w;
  logic                  rem_done;
  logic [63:0]           rem_val;
  logic [63:0]           res_d;

  assign mixed_w = (state_q ^ (state_q >> 18)) >> 27;
  assign rot_w   = {mixed_w[31:0], mixed_w[31:0]} >> state_q[63:59];
  assign draw_w  = rot_w[31:0];

  assign mul_a = (step_q == 2'd1) ? mul_x_q[63:32] : mul_x_q[31:0];
  assign mul_b = (step_q == 2'd2) ? PCG_MUL[63:32] : PCG_MUL[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RESET_STATE;
      busy_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      if (cmd_i.draw_start || cmd_i.mul_go) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == 2'd3) begin
          busy_q  <= 1'b0;
          state_q <= acc_q + {prod_q[31:0], 32'b0} + PCG_INC;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    unique case (step_q)
      2'd1:    acc_q <= prod_q;
      2'd2:    acc_q <= acc_q + {prod_q[31:0], 32'b0};
      default: acc_q <= acc_q;
    endcase
    if (cfg_we_i) begin
      mul_x_q <= PCG_INC + cfg_wdata_i;
    end else if (cmd_i.draw_start) begin
      mul_x_q <= state_q;
    end
    if (cmd_i.draw_start) begin
      r_q <= draw_w;
    end
    if (cmd_i.save_hi) begin
      hi_q <= r_q;
    end
    if (cmd_i.capture) begin
      act_q      <= in_data_i.action;
      lo_q       <= in_data_i.range_low;
      hi_bound_q <= in_data_i.range_high;
      span_q     <= in_data_i.range_high - in_data_i.range_low + 64'd1;
    end
    if (cmd_i.thr_load) begin
      thr_q <= rem_val;
    end
    if (cmd_i.res_load) begin
      res_q  <= res_d;
      gave_q <= cmd_i.gave_up;
    end
    if (cmd_i.out_load) begin
      out_q.value   <= res_q;
      out_q.gave_up <= gave_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.draw_start) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_comb begin
    unique case (cmd_i.res_sel)
      RES_DRAW:    res_d = {32'b0, r_q};
      RES_HI_LO:   res_d = {hi_q, r_q};
      RES_LO:      res_d = lo_q;
      RES_LO_DRAW: res_d = lo_q + {32'b0, r_q};
      RES_LO_REM:  res_d = lo_q + rem_val;
      default:     res_d = '0;
    endcase
  end

  pcg_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_thr ? 64'(64'd0 - span_q) : {32'b0, r_q}),
    .divisor_i  (span_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  assign status_o.mul_done  = busy_q && (step_q == 2'd3);
  assign status_o.div_done  = rem_done;
  assign status_o.inverted  = $signed(lo_q) > $signed(hi_bound_q);
  assign status_o.span_zero = (span_q == 64'd0);
  assign status_o.draw_ok   = ({32'b0, r_q} >= thr_q);
  assign status_o.cnt_max   = (cnt_q == DRAW_CNT_W'(MAX_DRAWS));
  assign status_o.action    = act_q;

  assign out_data_o = out_q;

endmodule

FILE: sv/pcg_ctrl.sv
module pcg_ctrl import pcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       in_valid_i,
  input  logic [1:0] in_action_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_GO,
    S_SEED_W,
    S_RANGE,
    S_DRAW,
    S_DRAW_W,
    S_DIV_W,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   second_q, second_d;
  logic   thr_q, thr_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    second_d    = second_q;
    thr_d       = thr_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.res_sel = RES_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          second_d      = 1'b0;
          unique case (in_action_i)
            ACT_U32, ACT_U64: state_d = S_DRAW;
            ACT_RANGE:        state_d = S_RANGE;
            default: begin
              cmd_o.res_load = 1'b1;
              state_d        = S_OUT;
            end
          endcase
        end
      end
      S_SEED_GO: begin
        cmd_o.mul_go = 1'b1;
        state_d      = S_SEED_W;
      end
      S_SEED_W: begin
        if (status_i.mul_done) begin
          state_d = S_IDLE;
        end
      end
      S_RANGE: begin
        cmd_o.cnt_clr = 1'b1;
        priority if (status_i.inverted) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_LO;
          state_d        = S_OUT;
        end else if (status_i.span_zero) begin
          state_d = S_DRAW;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_thr   = 1'b1;
          thr_d           = 1'b1;
          state_d         = S_DIV_W;
        end
      end
      S_DRAW: begin
        cmd_o.draw_start = 1'b1;
        state_d          = S_DRAW_W;
      end
      S_DRAW_W: begin
        if (status_i.mul_done) begin
          unique case (status_i.action)
            ACT_U32: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_DRAW;
              state_d        = S_OUT;
            end
            ACT_U64: begin
              if (!second_q) begin
                cmd_o.save_hi = 1'b1;
                second_d      = 1'b1;
                state_d       = S_DRAW;
              end else begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = RES_HI_LO;
                state_d        = S_OUT;
              end
            end
            default: begin
              priority if (status_i.span_zero) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = RES_LO_DRAW;
                state_d        = S_OUT;
              end else if (status_i.draw_ok) begin
                cmd_o.div_start = 1'b1;
                thr_d           = 1'b0;
                state_d         = S_DIV_W;
              end else if (status_i.cnt_max) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = RES_LO;
                cmd_o.gave_up  = 1'b1;
                state_d        = S_OUT;
              end else begin
                state_d = S_DRAW;
              end
            end
          endcase
        end
      end
      S_DIV_W: begin
        cmd_o.div_thr = thr_q;
        if (status_i.div_done) begin
          if (thr_q) begin
            cmd_o.thr_load = 1'b1;
            state_d        = S_DRAW;
          end else begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_LO_REM;
            state_d        = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = S_SEED_GO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      second_q    <= 1'b0;
      thr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      thr_q       <= thr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/pcg32_random_generator_top.sv
// PCG32 (XSH-RR) random generator.
// Input channel in_valid_i / in_stall_o carries one request transaction:
// action 0 = one 32-bit draw, 1 = 64-bit value (two draws, high word first),
// 2 = integer in [range_low, range_high], 3 = value 0 with no draw.
// Output channel out_valid_o / out_stall_i carries one result transaction
// per request: value and gave_up.
// A draw is paced by the 64x64 state multiply, run as three 32x32 partial
// products on one multiplier. A range request adds a threshold remainder,
// one draw per try (up to MAX_DRAWS draws) and a final remainder, all on
// one bit-serial remainder unit; inverted bounds take no draw, and a range
// of all 2^64 values takes one draw and no remainder.
// One request is worked at a time; a new one is taken once the previous
// result sits in the output register, even while the receiver stalls it.
// A write on cfg_we_i reseeds the state, with in_stall_o high until it is done.
// Reset loads the state seeded with zero and empties the output register.
module pcg32_random_generator_top import pcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pcg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule
